### design/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// shared types and constants of the sobel edge threshold block
// ----------------------------------------------------------------------------
package sobel_pkg;

   localparam int PIXEL_W      = 8;
   localparam int ROW_W        = 13;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int THR_W        = 11;
   localparam int COL_SUM_W    = 10;
   localparam int GRAD_W       = 11;
   localparam int ABS_W        = 10;
   localparam int SQ_W         = 20;
   localparam int MAG_W        = 21;
   localparam int THR_SQ_W     = 22;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   // register map, index = paddr[3:2]
   localparam logic [1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_EDGE_THRESHOLD = 2'd2;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET     = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET    = 13'd480;
   localparam logic [THR_W-1:0]        THRESHOLD_RESET = 11'd128;
   localparam logic [ROW_W-1:0]        HEIGHT_LIMIT    = 13'd4096;

   localparam logic [PIXEL_W-1:0] EDGE_ON  = 8'd255;
   localparam logic [PIXEL_W-1:0] EDGE_OFF = 8'd0;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_red;
      logic               drain;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] edge_value;
      logic               frame_last;
   } rsp_payload_type;

   // one line store entry: same column of the two previous rows
   typedef struct packed {
      logic [PIXEL_W-1:0] upper;
      logic [PIXEL_W-1:0] lower;
   } line_word_type;

   // one window column, top row first
   typedef struct packed {
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] mid;
      logic [PIXEL_W-1:0] bot;
   } tap_column_type;

   // which window border taps lie inside the image
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } tap_mask_type;

endpackage

### design/sobel_line_store.sv
// ----------------------------------------------------------------------------
// sobel_line_store
// two-row line store in one memory, registered read, write-to-read forwarding
// ----------------------------------------------------------------------------
module sobel_line_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  sobel_pkg::line_word_type wr_data,
   output sobel_pkg::line_word_type rd_data
);

   sobel_pkg::line_word_type line_mem_ff [DEPTH];
   sobel_pkg::line_word_type rd_word_ff;
   sobel_pkg::line_word_type fwd_word_ff;
   logic                     fwd_ff;
   logic                     fwd_in;

   // read and write of the same entry at one edge: memory returns old data
   assign fwd_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff  <= line_mem_ff[rd_addr];
         fwd_word_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_word_ff : rd_word_ff;

endmodule

### design/sobel_window.sv
// ----------------------------------------------------------------------------
// sobel_window
// 3x3 tap window with border masking and registered sobel gradients
// ----------------------------------------------------------------------------
module sobel_window (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  shift_en,
   input  sobel_pkg::tap_column_type             col_in,
   input  sobel_pkg::tap_mask_type               mask,
   output logic signed [sobel_pkg::GRAD_W-1:0]   gx,
   output logic signed [sobel_pkg::GRAD_W-1:0]   gy
);

   sobel_pkg::tap_column_type col_a_ff;
   sobel_pkg::tap_column_type col_b_ff;
   sobel_pkg::tap_column_type left_col;
   sobel_pkg::tap_column_type centre_col;
   sobel_pkg::tap_column_type right_col;
   logic [sobel_pkg::COL_SUM_W-1:0] left_sum;
   logic [sobel_pkg::COL_SUM_W-1:0] right_sum;
   logic [sobel_pkg::COL_SUM_W-1:0] top_sum;
   logic [sobel_pkg::COL_SUM_W-1:0] bot_sum;
   logic signed [sobel_pkg::GRAD_W-1:0] gx_in;
   logic signed [sobel_pkg::GRAD_W-1:0] gy_in;
   logic signed [sobel_pkg::GRAD_W-1:0] gx_ff;
   logic signed [sobel_pkg::GRAD_W-1:0] gy_ff;

   function automatic sobel_pkg::tap_column_type mask_column(
      sobel_pkg::tap_column_type col, logic keep, sobel_pkg::tap_mask_type m);
      sobel_pkg::tap_column_type res;
      res.top = (keep && m.top)    ? col.top : '0;
      res.mid = keep               ? col.mid : '0;
      res.bot = (keep && m.bottom) ? col.bot : '0;
      return res;
   endfunction

   // a + 2b + c
   function automatic logic [sobel_pkg::COL_SUM_W-1:0] weighted_sum(
      logic [sobel_pkg::PIXEL_W-1:0] a, logic [sobel_pkg::PIXEL_W-1:0] b,
      logic [sobel_pkg::PIXEL_W-1:0] c);
      return sobel_pkg::COL_SUM_W'(a) + {1'b0, b, 1'b0} + sobel_pkg::COL_SUM_W'(c);
   endfunction

   // window after the shift: older column, newer column, incoming column
   always_comb begin
      left_col   = mask_column(col_a_ff, mask.left, mask);
      centre_col = mask_column(col_b_ff, 1'b1, mask);
      right_col  = mask_column(col_in, mask.right, mask);
      left_sum   = weighted_sum(left_col.top, left_col.mid, left_col.bot);
      right_sum  = weighted_sum(right_col.top, right_col.mid, right_col.bot);
      top_sum    = weighted_sum(left_col.top, centre_col.top, right_col.top);
      bot_sum    = weighted_sum(left_col.bot, centre_col.bot, right_col.bot);
      gx_in      = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
      gy_in      = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_a_ff <= '0;
         col_b_ff <= '0;
      end else if (shift_en) begin
         col_a_ff <= col_b_ff;
         col_b_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
   end

   assign gx = gx_ff;
   assign gy = gy_ff;

endmodule

### design/sobel_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_magnitude
// squared gradient magnitude against squared threshold
// ----------------------------------------------------------------------------
module sobel_magnitude (
   input  logic                                clock,
   input  logic                                load_en,
   input  logic signed [sobel_pkg::GRAD_W-1:0] gx,
   input  logic signed [sobel_pkg::GRAD_W-1:0] gy,
   input  logic [sobel_pkg::THR_W-1:0]         threshold,
   output logic                                is_edge
);

   logic signed [sobel_pkg::GRAD_W-1:0] gx_neg;
   logic signed [sobel_pkg::GRAD_W-1:0] gy_neg;
   logic [sobel_pkg::ABS_W-1:0]         gx_abs;
   logic [sobel_pkg::ABS_W-1:0]         gy_abs;
   logic [sobel_pkg::SQ_W-1:0]          sq_x;
   logic [sobel_pkg::SQ_W-1:0]          sq_y;
   logic [sobel_pkg::MAG_W-1:0]         mag_in;
   logic [sobel_pkg::MAG_W-1:0]         mag_ff;
   logic [sobel_pkg::THR_SQ_W-1:0]      thr_sq_in;
   logic [sobel_pkg::THR_SQ_W-1:0]      thr_sq_ff;

   assign gx_neg = -gx;
   assign gy_neg = -gy;
   assign gx_abs = gx[sobel_pkg::GRAD_W-1] ? gx_neg[sobel_pkg::ABS_W-1:0]
                                           : gx[sobel_pkg::ABS_W-1:0];
   assign gy_abs = gy[sobel_pkg::GRAD_W-1] ? gy_neg[sobel_pkg::ABS_W-1:0]
                                           : gy[sobel_pkg::ABS_W-1:0];
   assign sq_x      = sobel_pkg::SQ_W'(gx_abs) * sobel_pkg::SQ_W'(gx_abs);
   assign sq_y      = sobel_pkg::SQ_W'(gy_abs) * sobel_pkg::SQ_W'(gy_abs);
   assign mag_in    = {1'b0, sq_x} + {1'b0, sq_y};
   assign thr_sq_in = sobel_pkg::THR_SQ_W'(threshold) * sobel_pkg::THR_SQ_W'(threshold);

   always_ff @(posedge clock) begin
      thr_sq_ff <= thr_sq_in;
      if (load_en) begin
         mag_ff <= mag_in;
      end
   end

   assign is_edge = {1'b0, mag_ff} > thr_sq_ff;

endmodule

### design/sobel_edge_threshold.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// 3x3 sobel edge detector with magnitude threshold on a raster pixel stream
// ----------------------------------------------------------------------------
// usage:
//  - req channel carries one pixel beat per pixel in raster order; after the
//    last pixel of a frame send image_width + 1 beats with drain set
//  - a drain beat while the frame still expects pixels is taken and dropped
//  - rsp channel gives one beat per image pixel, 255 for an edge else 0, the
//    result for pixel m comes with input beat m + image_width + 1;
//    frame_last marks the result for the frame's last pixel
//  - a result passes the stage 1, gradient, magnitude and output registers;
//    throughput is one beat per cycle while rsp_ready is high, set by the
//    single read port and single write port of the line store memory
//  - csr port (apb style, pready tied high) holds image_width, image_height
//    and edge_threshold; write it only while the block is idle
//  - reset empties the pipeline and restarts the frame position; line store
//    contents are kept, and an entry's data is used only after it is written
//  - when rsp_ready is low, results wait in the output register and the
//    pipeline stages behind it keep filling; req_ready drops only when
//    every stage holds an item
// ----------------------------------------------------------------------------
module sobel_edge_threshold #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sobel_pkg::req_payload_type            req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sobel_pkg::rsp_payload_type            rsp_payload,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sobel_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sobel_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sobel_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = ($clog2(MAX_WIDTH + 1) > sobel_pkg::WIDTH_REG_W) ?
                          $clog2(MAX_WIDTH + 1) : sobel_pkg::WIDTH_REG_W;
   localparam logic [WID_W-1:0] MAX_W = WID_W'(MAX_WIDTH);
   localparam int ROW_W = sobel_pkg::ROW_W;

   // configuration registers
   logic [sobel_pkg::WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [sobel_pkg::HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [sobel_pkg::THR_W-1:0]        thr_ff, thr_in;
   logic                               csr_write;
   logic [1:0]                         csr_reg_idx;

   // frame position
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // accept stage decode
   logic [WID_W-1:0]  eff_w;
   logic [ROW_W-1:0]  eff_h;
   logic              accept;
   logic              ignore;
   logic              take;
   logic [COL_W-1:0]  col_cur;
   logic              col_zero;
   logic              row_ok;
   logic [ROW_W-1:0]  ctr_row;
   logic              abort;
   logic              have;
   logic              last;
   logic [WID_W-1:0]  col_next;
   sobel_pkg::tap_mask_type mask;

   // pipeline control
   logic adv1, adv2, adv3, s1_leave;
   logic s1_v_ff, s1_v_in;
   logic s2_v_ff, s2_v_in, s2_last_ff, s2_last_in;
   logic s3_v_ff, s3_v_in, s3_last_ff, s3_last_in;
   logic rsp_valid_ff, rsp_valid_in;
   sobel_pkg::rsp_payload_type rsp_payload_ff;

   // stage 1 payload: memory read in flight
   logic [COL_W-1:0]                s1_addr_ff;
   logic [sobel_pkg::PIXEL_W-1:0]   s1_px_ff;
   sobel_pkg::tap_mask_type         s1_mask_ff;
   logic                            s1_have_ff;
   logic                            s1_last_ff;

   sobel_pkg::line_word_type  line_rd;
   sobel_pkg::line_word_type  line_wr;
   sobel_pkg::tap_column_type new_col;
   logic signed [sobel_pkg::GRAD_W-1:0] gx, gy;
   logic is_edge;

   // ---------------------------------------------------------------- csr port
   assign csr_pready  = 1'b1;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg_idx = csr_paddr[sobel_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thr_in    = thr_ff;
      if (csr_write) begin
         case (csr_reg_idx)
            sobel_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_pwdata[sobel_pkg::WIDTH_REG_W-1:0];
            end
            sobel_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_pwdata[sobel_pkg::HEIGHT_REG_W-1:0];
            end
            sobel_pkg::CSR_EDGE_THRESHOLD: begin
               thr_in = csr_pwdata[sobel_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_reg_idx)
         sobel_pkg::CSR_IMAGE_WIDTH:    csr_prdata = sobel_pkg::CSR_DATA_W'(width_ff);
         sobel_pkg::CSR_IMAGE_HEIGHT:   csr_prdata = sobel_pkg::CSR_DATA_W'(height_ff);
         sobel_pkg::CSR_EDGE_THRESHOLD: csr_prdata = sobel_pkg::CSR_DATA_W'(thr_ff);
         default:                       csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------ effective geometry
   // zero width or height acts as one, oversize values clamp
   assign eff_w = (width_ff == '0) ? WID_W'(1) :
                  ((WID_W'(width_ff) > MAX_W) ? MAX_W : WID_W'(width_ff));
   assign eff_h = (height_ff == '0) ? ROW_W'(1) :
                  ((height_ff > sobel_pkg::HEIGHT_LIMIT) ? sobel_pkg::HEIGHT_LIMIT
                                                         : height_ff);

   // ------------------------------------------------------------ accept stage
   assign accept = req_valid && req_ready;
   // drain beats inside the image are swallowed without effect
   assign ignore = req_payload.drain && (row_ff < eff_h);
   assign take   = accept && !ignore;

   always_comb begin
      // column restarts if the width shrank under it
      col_cur  = (WID_W'(col_ff) >= eff_w) ? '0 : col_ff;
      col_zero = (col_cur == '0);
      // at column zero the window centre is the last column two rows up,
      // elsewhere it is one row up and one column left
      row_ok   = col_zero ? (row_ff >= ROW_W'(2)) : (row_ff != '0);
      ctr_row  = col_zero ? (row_ff - ROW_W'(2)) : (row_ff - ROW_W'(1));
      abort    = row_ok && (ctr_row >= eff_h);
      have     = row_ok && !abort;
      last     = have && col_zero && (ctr_row == (eff_h - ROW_W'(1)));
      mask.top    = (ctr_row != '0);
      mask.bottom = ({1'b0, ctr_row} + (ROW_W + 1)'(1)) < {1'b0, eff_h};
      mask.left   = col_zero ? (eff_w >= WID_W'(2)) : (col_cur >= COL_W'(2));
      mask.right  = !col_zero;
      col_next    = WID_W'(col_cur) + WID_W'(1);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (abort || last) begin
            // frame end, or height shrank below the due result
            col_in = '0;
            row_in = '0;
         end else if (col_next >= eff_w) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   // -------------------------------------------------------- pipeline control
   // every stage moves when the one in front is free or moving
   assign adv3      = !rsp_valid_ff || rsp_ready;
   assign adv2      = !s3_v_ff || adv3;
   assign adv1      = !s2_v_ff || adv2;
   assign s1_leave  = s1_v_ff && adv1;
   assign req_ready = !s1_v_ff || adv1;

   always_comb begin
      s1_v_in      = take || (s1_v_ff && !adv1);
      // items without a result stop after the window shift
      s2_v_in      = adv1 ? (s1_v_ff && s1_have_ff) : s2_v_ff;
      s2_last_in   = adv1 ? s1_last_ff : s2_last_ff;
      s3_v_in      = adv2 ? s2_v_ff : s3_v_ff;
      s3_last_in   = adv2 ? s2_last_ff : s3_last_ff;
      rsp_valid_in = adv3 ? s3_v_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= sobel_pkg::WIDTH_RESET;
         height_ff    <= sobel_pkg::HEIGHT_RESET;
         thr_ff       <= sobel_pkg::THRESHOLD_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         thr_ff       <= thr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         s3_v_ff      <= s3_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         s1_addr_ff <= col_cur;
         s1_px_ff   <= req_payload.pixel_red;
         s1_mask_ff <= mask;
         s1_have_ff <= have;
         s1_last_ff <= last;
      end
      s2_last_ff <= s2_last_in;
      s3_last_ff <= s3_last_in;
      if (adv3) begin
         rsp_payload_ff.edge_value <= is_edge ? sobel_pkg::EDGE_ON : sobel_pkg::EDGE_OFF;
         rsp_payload_ff.frame_last <= s3_last_ff;
      end
   end

   // -------------------------------------------------------------- line store
   // read when a beat is taken, write back {lower, pixel} when the item leaves stage 1
   assign line_wr.upper = line_rd.lower;
   assign line_wr.lower = s1_px_ff;

   sobel_line_store #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (take),
      .rd_addr (col_cur),
      .wr_en   (s1_leave),
      .wr_addr (s1_addr_ff),
      .wr_data (line_wr),
      .rd_data (line_rd)
   );

   // ------------------------------------------------------------ window + math
   assign new_col.top = line_rd.upper;
   assign new_col.mid = line_rd.lower;
   assign new_col.bot = s1_px_ff;

   sobel_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_leave),
      .col_in   (new_col),
      .mask     (s1_mask_ff),
      .gx       (gx),
      .gy       (gy)
   );

   sobel_magnitude u_magnitude (
      .clock     (clock),
      .load_en   (adv2),
      .gx        (gx),
      .gy        (gy),
      .threshold (thr_ff),
      .is_edge   (is_edge)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### design/sobel_checker.sv
// ----------------------------------------------------------------------------
// sobel_checker
// port-level checks of the sobel edge threshold block
// ----------------------------------------------------------------------------
module sobel_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input sobel_pkg::rsp_payload_type rsp_payload
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   // result is binary edge code
   a_edge_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.edge_value == sobel_pkg::EDGE_ON ||
                     rsp_payload.edge_value == sobel_pkg::EDGE_OFF))
      else $error("edge_value not an edge code");

   // reset empties the output register
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // reset empties the pipeline, so input is taken right away
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready after reset");

endmodule

bind sobel_edge_threshold sobel_checker u_sobel_checker (.*);

### tb/sv/sobel_edge_threshold_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_threshold_test
// self-checking bench: streams raster frames of red pixels through the edge
// detector under random bursts and receiver stalls, predicts every result
// beat from its own window and line store copy, and checks the csr port
// ----------------------------------------------------------------------------
module sobel_edge_threshold_test;

   localparam int LINE_DEPTH   = 1024;
   localparam int CLOCK_HALF   = 4;
   localparam int FLUSH_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 700;
   localparam int PRINT_CAP    = 100;

   typedef logic [sobel_pkg::PIXEL_W-1:0] tap_set_type [9];

   // ------------------------------------------------------------------------
   // scoreboard: own copy of window, line stores, position and registers
   // ------------------------------------------------------------------------
   class edge_map_checker;
      logic [sobel_pkg::WIDTH_REG_W-1:0]  width_reg;
      logic [sobel_pkg::HEIGHT_REG_W-1:0] height_reg;
      logic [sobel_pkg::THR_W-1:0]        thr_reg;
      logic [sobel_pkg::PIXEL_W-1:0]      upper_row [LINE_DEPTH];
      logic [sobel_pkg::PIXEL_W-1:0]      lower_row [LINE_DEPTH];
      tap_set_type                        taps;
      int unsigned                        col;
      int unsigned                        row;
      sobel_pkg::rsp_payload_type         edge_beats_due [$];
      int                                 errors;
      int                                 results;

      function new();
         width_reg  = sobel_pkg::WIDTH_RESET;
         height_reg = sobel_pkg::HEIGHT_RESET;
         thr_reg    = sobel_pkg::THRESHOLD_RESET;
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            lower_row[i] = '0;
         end
         foreach (taps[i]) taps[i] = '0;
         col     = 0;
         row     = 0;
         errors  = 0;
         results = 0;
      endfunction

      task report(string what);
         if (errors < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      function void write_reg(logic [1:0] idx, logic [sobel_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            sobel_pkg::CSR_IMAGE_WIDTH:    width_reg  = value[sobel_pkg::WIDTH_REG_W-1:0];
            sobel_pkg::CSR_IMAGE_HEIGHT:   height_reg = value[sobel_pkg::HEIGHT_REG_W-1:0];
            sobel_pkg::CSR_EDGE_THRESHOLD: thr_reg    = value[sobel_pkg::THR_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > LINE_DEPTH) return LINE_DEPTH;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg == 0) return 1;
         if (height_reg > int'(sobel_pkg::HEIGHT_LIMIT)) return int'(sobel_pkg::HEIGHT_LIMIT);
         return height_reg;
      endfunction

      // sobel magnitude against threshold, taps outside the image read zero
      function logic [sobel_pkg::PIXEL_W-1:0] gradient_edge(tap_set_type t, bit top_ok,
                                                            bit bot_ok, bit left_ok,
                                                            bit right_ok);
         int     v [9];
         int     gx;
         int     gy;
         longint mag;
         longint lim;
         for (int k = 0; k < 9; k++) begin
            v[k] = t[k];
            if (k < 3 && !top_ok) v[k] = 0;
            if (k >= 6 && !bot_ok) v[k] = 0;
            if (k % 3 == 0 && !left_ok) v[k] = 0;
            if (k % 3 == 2 && !right_ok) v[k] = 0;
         end
         gx  = (v[2] + 2 * v[5] + v[8]) - (v[0] + 2 * v[3] + v[6]);
         gy  = (v[6] + 2 * v[7] + v[8]) - (v[0] + 2 * v[1] + v[2]);
         mag = longint'(gx) * gx + longint'(gy) * gy;
         lim = longint'(thr_reg) * longint'(thr_reg);
         return (mag > lim) ? sobel_pkg::EDGE_ON : sobel_pkg::EDGE_OFF;
      endfunction

      function void restart();
         col = 0;
         row = 0;
      endfunction

      // one accepted input beat: advance the window, queue the result it frees
      function void take_pixel(sobel_pkg::req_payload_type beat);
         int unsigned                   w;
         int unsigned                   h;
         int unsigned                   r;
         int unsigned                   c;
         int unsigned                   cr;
         int unsigned                   cc;
         bit                            have;
         bit                            last;
         logic [sobel_pkg::PIXEL_W-1:0] edge_val;
         tap_set_type                   t;
         w        = eff_width();
         h        = eff_height();
         cr       = 0;
         cc       = 0;
         have     = 0;
         edge_val = sobel_pkg::EDGE_OFF;
         // drain while the frame still wants pixels: dropped
         if (beat.drain && row < h) return;
         if (col >= w) col = 0;
         r = row;
         c = col;
         // first column: last pixel of the row two back is now complete
         if (c == 0 && r >= 2) begin
            cr   = r - 2;
            cc   = w - 1;
            have = 1;
            if (cr < h) begin
               for (int k = 0; k < 3; k++) begin
                  t[k * 3]     = taps[k * 3 + 1];
                  t[k * 3 + 1] = taps[k * 3 + 2];
                  t[k * 3 + 2] = '0;
               end
               edge_val = gradient_edge(t, cr >= 1, cr + 1 < h, cc >= 1, 1'b0);
            end
         end
         for (int k = 0; k < 3; k++) begin
            taps[k * 3]     = taps[k * 3 + 1];
            taps[k * 3 + 1] = taps[k * 3 + 2];
         end
         taps[2]      = upper_row[c];
         taps[5]      = lower_row[c];
         taps[8]      = beat.pixel_red;
         upper_row[c] = lower_row[c];
         lower_row[c] = beat.pixel_red;
         if (c >= 1 && r >= 1) begin
            cr   = r - 1;
            cc   = c - 1;
            have = 1;
            if (cr < h) edge_val = gradient_edge(taps, cr >= 1, cr + 1 < h, cc >= 1, cc + 1 < w);
         end
         if (have && cr >= h) begin
            restart();
            return;
         end
         if (have) begin
            last = (cr == h - 1) && (cc == w - 1);
            edge_beats_due.push_back('{edge_value: edge_val, frame_last: last});
            if (last) begin
               restart();
               return;
            end
         end
         col = c + 1;
         if (col >= w) begin
            col = 0;
            row = (r + 1) & 32'h1FFF;
         end
      endfunction

      // one accepted result beat against the oldest pending one
      task match_edge(sobel_pkg::rsp_payload_type got);
         sobel_pkg::rsp_payload_type want;
         if (edge_beats_due.size() == 0) begin
            report($sformatf("result beat %0d arrived with nothing pending", results));
            return;
         end
         want = edge_beats_due.pop_front();
         if (got.edge_value !== want.edge_value)
            report($sformatf("result %0d edge_value got %0d want %0d",
                             results, got.edge_value, want.edge_value));
         if (got.frame_last !== want.frame_last)
            report($sformatf("result %0d frame_last got %0b want %0b",
                             results, got.frame_last, want.frame_last));
         results++;
      endtask
   endclass

   // ------------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // ------------------------------------------------------------------------
   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_ready;
   sobel_pkg::req_payload_type          req_payload = '0;
   logic                                rsp_valid;
   logic                                rsp_ready   = 1'b0;
   sobel_pkg::rsp_payload_type          rsp_payload;
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [sobel_pkg::CSR_ADDR_W-1:0]    csr_paddr   = '0;
   logic [sobel_pkg::CSR_DATA_W-1:0]    csr_pwdata  = '0;
   logic [sobel_pkg::CSR_DATA_W-1:0]    csr_prdata;
   logic                                csr_pready;

   edge_map_checker sb;
   int   cycle_count  = 0;
   logic [15:0] rx_tick = '0;
   int   burst_left   = 0;
   int   frame_items  = 0;
   int   frames_done  = 0;
   int   settings_done = 0;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   sobel_edge_threshold i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // run limit, far above the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, sb.edge_beats_due.size());
         $display("** sobel_edge_threshold: FAILED **");
         $finish;
      end
   end

   // result side: check every accepted beat, stall in four rotating moods
   always @(posedge clock) begin
      rx_tick <= rx_tick + 16'd1;
      if (!reset && rsp_valid && rsp_ready) sb.match_edge(rsp_payload);
      case (rx_tick[9:8])
         2'd0:    rsp_ready <= 1'b1;                          // no stalls
         2'd1:    rsp_ready <= ($urandom_range(0, 3) != 0);   // light random
         2'd2:    rsp_ready <= ((rx_tick % 7) >= 3);          // periodic 3 of 7 low
         default: rsp_ready <= ($urandom_range(0, 1) != 0);   // heavy random
      endcase
   end

   // ------------------------------------------------------------------------
   // driver tasks
   // ------------------------------------------------------------------------

   // one input beat; bursts of random length with random gaps between them
   task automatic send_beat(input logic [sobel_pkg::PIXEL_W-1:0] px, input logic is_drain);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= '{pixel_red: px, drain: is_drain};
      do @(posedge clock); while (!req_ready);
      sb.take_pixel(req_payload);
   endtask

   // apb write followed back to back by a read of the same register
   task automatic csr_write_check(input logic [1:0] idx,
                                  input logic [sobel_pkg::CSR_DATA_W-1:0] value);
      logic [sobel_pkg::CSR_DATA_W-1:0] want;
      want = '0;
      case (idx)
         sobel_pkg::CSR_IMAGE_WIDTH:
            want[sobel_pkg::WIDTH_REG_W-1:0] = value[sobel_pkg::WIDTH_REG_W-1:0];
         sobel_pkg::CSR_IMAGE_HEIGHT:
            want[sobel_pkg::HEIGHT_REG_W-1:0] = value[sobel_pkg::HEIGHT_REG_W-1:0];
         sobel_pkg::CSR_EDGE_THRESHOLD:
            want[sobel_pkg::THR_W-1:0] = value[sobel_pkg::THR_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      // read setup, psel stays high
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         sb.report($sformatf("csr %0d read back %0h want %0h", idx, csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input int unsigned w, input int unsigned h, input int unsigned thr);
      csr_write_check(sobel_pkg::CSR_IMAGE_WIDTH, w);
      csr_write_check(sobel_pkg::CSR_IMAGE_HEIGHT, h);
      csr_write_check(sobel_pkg::CSR_EDGE_THRESHOLD, thr);
      settings_done++;
   endtask

   // block idle: input low, every result in, pipeline flushed of dropped beats
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.edge_beats_due.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   function automatic logic [sobel_pkg::PIXEL_W-1:0] pick_pixel(int style, int base);
      int v;
      case (style)
         0: v = $urandom_range(0, 255);
         1: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
         default: begin
            // smooth area with small noise, edges only at low thresholds
            v = base + $urandom_range(0, 24) - 12;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
      endcase
      return v[sobel_pkg::PIXEL_W-1:0];
   endfunction

   // one whole frame at the current setting, pixels then width + 1 drains;
   // noisy frames also carry dropped drains and pixels in the drain tail
   task automatic run_frame(input bit noisy);
      int unsigned w;
      int unsigned h;
      int          style;
      int          base;
      w     = sb.eff_width();
      h     = sb.eff_height();
      style = $urandom_range(0, 2);
      base  = $urandom_range(0, 255);
      for (int unsigned p = 0; p < w * h; p++) begin
         if (noisy && $urandom_range(0, 15) == 0) send_beat(8'($urandom), 1'b1);
         send_beat(pick_pixel(style, base), 1'b0);
      end
      for (int unsigned d = 0; d <= w; d++)
         send_beat(8'($urandom), noisy ? ($urandom_range(0, 3) != 0) : 1'b1);
      frames_done++;
      frame_items += w * h + w + 1;
   endtask

   task automatic random_setting();
      int unsigned w;
      int unsigned h;
      int unsigned thr;
      case ($urandom_range(0, 9))
         0:       w = 0;
         1:       w = $urandom_range(9, 40);
         default: w = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
         0:       h = 0;
         1:       h = $urandom_range(7, 12);
         default: h = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
         0:          thr = 0;
         1:          thr = 1443;
         2:          thr = 2047;
         3, 4, 5:    thr = $urandom_range(0, 1443);
         default:    thr = $urandom_range(0, 300);
      endcase
      configure(w, h, thr);
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      int start_items;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: 3x3 at threshold zero, a drain inside the image is dropped,
      // a plain pixel in the drain tail counts as drain
      configure(3, 3, 0);
      send_beat(8'd0, 1'b1);
      send_beat(8'd0, 1'b0);
      send_beat(8'd255, 1'b1);
      send_beat(8'd255, 1'b0);
      send_beat(8'd0, 1'b0);
      send_beat(8'd255, 1'b0);
      send_beat(8'd0, 1'b0);
      send_beat(8'd255, 1'b0);
      send_beat(8'd0, 1'b0);
      send_beat(8'd255, 1'b0);
      send_beat(8'd255, 1'b0);
      send_beat(8'd0, 1'b1);
      send_beat(8'd255, 1'b0);
      send_beat(8'd0, 1'b1);
      send_beat(8'd0, 1'b1);
      wait_drained();

      // zero width and height act as one, threshold above the largest magnitude
      configure(0, 0, 1443);
      send_beat(8'd255, 1'b0);
      send_beat(8'd0, 1'b1);
      send_beat(8'd0, 1'b1);
      wait_drained();

      // single row, threshold one
      configure(2, 1, 1);
      send_beat(8'd255, 1'b0);
      send_beat(8'd0, 1'b0);
      send_beat(8'd0, 1'b1);
      send_beat(8'd127, 1'b0);
      send_beat(8'd0, 1'b1);
      wait_drained();
      frames_done += 3;

      // random small frames, a few per setting
      start_items = frame_items;
      while (frame_items - start_items < RANDOM_ITEMS) begin
         random_setting();
         repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 3) == 0);
         wait_drained();
      end

      $display("covered %0d small frames over %0d register settings, %0d frame beats",
               frames_done, settings_done, frame_items);
      $display("checked %0d result beats, %0d mismatches", sb.results, sb.errors);
      if (sb.errors == 0) begin
         $display("** sobel_edge_threshold: PASSED **");
      end else begin
         $display("** sobel_edge_threshold: FAILED **");
      end
      $finish;
   end

endmodule
